// ===== rtl/lidar_packet_scan_assembler_macros.svh =====
// ---------------------------------------------------------------------------
// Lidar packet scan assembler assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LIDAR_PACKET_SCAN_ASSEMBLER_MACROS_SVH
`define LIDAR_PACKET_SCAN_ASSEMBLER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lpsa_pkg.sv =====
// ---------------------------------------------------------------------------
// Lidar packet scan assembler package
// Operation codes, framing constants and the controller/datapath interface.
// ---------------------------------------------------------------------------
package lpsa_pkg;

  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;

  localparam logic [7:0] HEADER_BYTE = 8'h54;
  localparam logic [7:0] VERLEN_BYTE = 8'h2c;

  localparam int unsigned FULL_TURN    = 36000;
  localparam int unsigned POINTS_START = 6;

  // Width of the reduced span and of the angle step quotient.
  localparam int unsigned STEP_W = 16;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mod_step;
    logic div_init;
    logic walk_step;
    logic finish_load;
  } lpsa_cmd_t;

  typedef struct packed {
    logic walk_needed;
    logic span_ge_turn;
    logic out_free;
  } lpsa_status_t;

endpackage

// ===== rtl/lpsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Lidar packet scan assembler controller
// Sequences one beat at a time through execute, span reduction, step
// division, point walk and result hand-off.
// ---------------------------------------------------------------------------
module lpsa_ctrl import lpsa_pkg::*; #(
  parameter int unsigned POINTS_PER_PACKET = 12,
  parameter int unsigned PIDX_W            = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lpsa_status_t      status,
  output lpsa_cmd_t         cmd,
  output logic [PIDX_W-1:0] walk_idx
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [PIDX_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign walk_idx  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.walk_needed ? S_MOD : S_FINISH;
      end
      S_MOD: begin
        if (status.span_ge_turn) begin
          cmd.mod_step = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (cnt_r == PIDX_W'(POINTS_PER_PACKET - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/lpsa_dpath.sv =====
// ---------------------------------------------------------------------------
// Lidar packet scan assembler datapath
// Packet framing registers, span reduction, step divider, point walk,
// double-banked scan memory and the result register.
// ---------------------------------------------------------------------------
`include "lidar_packet_scan_assembler_macros.svh"

module lpsa_dpath import lpsa_pkg::*; #(
  parameter int unsigned MAX_POINTS        = 450,
  parameter int unsigned POINTS_PER_PACKET = 12,
  parameter int unsigned PIDX_W            = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpsa_cmd_t              cmd,
  input  logic [PIDX_W-1:0]      walk_idx,
  output lpsa_status_t           status,
  input  logic [1:0]             in_op,
  input  logic [7:0]             in_rx_byte,
  input  logic [8:0]             in_read_index,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned END_POS    = POINTS_START + 3 * POINTS_PER_PACKET;
  localparam int unsigned PACKET_LEN = END_POS + 5;
  localparam int unsigned POS_W      = $clog2(PACKET_LEN);
  localparam int unsigned CW         = $clog2(MAX_POINTS + 1);
  localparam int unsigned DEPTH      = 2 * MAX_POINTS;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned SPAN_W     = 18;
  // Reciprocal of the point count, exact for every span below 2**STEP_W.
  localparam int unsigned DIV_SHIFT  = STEP_W + $clog2(POINTS_PER_PACKET);
  localparam int unsigned DIV_RECIP  = ((1 << DIV_SHIFT) + POINTS_PER_PACKET - 1) /
                                       POINTS_PER_PACKET;
  localparam int unsigned PROD_W     = STEP_W + 17;

  // Latched beat.
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic [8:0] idx_r;

  // Framing state.
  logic [POS_W-1:0]  pos_r;
  logic [15:0]       start_r;
  logic [15:0]       end_r;
  logic [PIDX_W-1:0] pt_idx_r;
  logic [1:0]        part_r;
  logic [23:0]       pkt_pts_r [POINTS_PER_PACKET];

  // Span, step and walk.
  logic [SPAN_W-1:0] span_r;
  logic [STEP_W-1:0] quo_r;
  logic [15:0]       angle_r;
  logic [15:0]       prev_r;

  // Scan banks.
  logic          bank_r;
  logic [CW-1:0] wc_r;
  logic [CW-1:0] pc_r;
  logic          done_r;
  logic [23:0]   scan_mem [DEPTH];
  logic [23:0]   rd_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic              is_last;
  logic [PROD_W-1:0] step_prod;
  logic              publish;
  logic [CW-1:0]     wc_eff;
  logic              bank_eff;
  logic              store_ok;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              idx_ok;
  logic [16:0]       ang_sum;
  logic [15:0]       angle_nxt;
  logic [SPAN_W-1:0] span_nxt;
  logic [15:0]       res_dist;
  logic [7:0]        res_conf;
  logic [10:0]       cnt11;
  logic [10:0]       res_bytes;

  assign is_last = (pos_r == POS_W'(PACKET_LEN - 1));

  assign status.walk_needed  = (op_r == OP_RX) && is_last;
  assign status.span_ge_turn = (span_r >= SPAN_W'(FULL_TURN));
  assign status.out_free     = !out_valid_r || out_tready;

  // Span with two turns added so the difference never goes negative.
  assign span_nxt = SPAN_W'(end_r) + SPAN_W'(2 * FULL_TURN) - SPAN_W'(start_r);

  // Step is the reduced span divided by the point count, taken as a
  // multiplication by the rounded-up reciprocal and a shift.
  assign step_prod = PROD_W'(span_r[STEP_W-1:0]) * PROD_W'(DIV_RECIP);

  // Walk step: publish on an angle that goes backward, then store if room.
  assign publish  = (angle_r < prev_r);
  assign wc_eff   = publish ? '0 : wc_r;
  assign bank_eff = bank_r ^ publish;
  assign store_ok = (wc_eff < CW'(MAX_POINTS));
  assign wr_addr  = bank_eff ? (AW'(MAX_POINTS) + AW'(wc_eff)) : AW'(wc_eff);

  assign ang_sum   = {1'b0, angle_r} + {1'b0, quo_r};
  assign angle_nxt = (ang_sum >= 17'(FULL_TURN)) ? 16'(ang_sum - 17'(FULL_TURN))
                                                 : ang_sum[15:0];

  // Reads go to the bank not being filled.
  assign idx_ok  = (32'(idx_r) < 32'(MAX_POINTS));
  assign rd_addr = bank_r ? AW'(idx_r) : (AW'(MAX_POINTS) + AW'(idx_r));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      byte_r <= in_rx_byte;
      idx_r  <= in_read_index;
    end
  end

  // Packet framing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      end_r   <= '0;
    end else if (cmd.exec && op_r == OP_RX) begin
      if (pos_r == '0) begin
        if (byte_r == HEADER_BYTE) begin
          pos_r <= POS_W'(1);
        end
      end else if (pos_r == POS_W'(1)) begin
        pos_r <= (byte_r == VERLEN_BYTE) ? POS_W'(2) : '0;
      end else begin
        if (pos_r == POS_W'(POINTS_START - 2)) begin
          start_r[7:0] <= byte_r;
        end
        if (pos_r == POS_W'(POINTS_START - 1)) begin
          start_r[15:8] <= byte_r;
        end
        if (pos_r == POS_W'(END_POS)) begin
          end_r[7:0] <= byte_r;
        end
        if (pos_r == POS_W'(END_POS + 1)) begin
          end_r[15:8] <= byte_r;
        end
        pos_r <= is_last ? '0 : pos_r + 1'b1;
      end
    end
  end

  // Point bytes, collected lane by lane.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == OP_RX) begin
      if (pos_r == POS_W'(POINTS_START - 1)) begin
        pt_idx_r <= '0;
        part_r   <= '0;
      end
      if (pos_r >= POS_W'(POINTS_START) && pos_r < POS_W'(END_POS)) begin
        case (part_r)
          2'd0: pkt_pts_r[pt_idx_r][7:0]   <= byte_r;
          2'd1: pkt_pts_r[pt_idx_r][15:8]  <= byte_r;
          2'd2: pkt_pts_r[pt_idx_r][23:16] <= byte_r;
          default: begin
          end
        endcase
        if (part_r == 2'd2) begin
          part_r   <= '0;
          pt_idx_r <= pt_idx_r + 1'b1;
        end else begin
          part_r <= part_r + 1'b1;
        end
      end
    end
  end

  // Span reduction and step division.
  always_ff @(posedge clk) begin
    if (cmd.exec && status.walk_needed) begin
      span_r <= span_nxt;
    end else if (cmd.mod_step) begin
      span_r <= span_r - SPAN_W'(FULL_TURN);
    end
    if (cmd.div_init) begin
      quo_r <= STEP_W'(step_prod >> DIV_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      angle_r <= start_r;
    end else if (cmd.walk_step) begin
      angle_r <= angle_nxt;
    end
  end

  // Bank bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      wc_r   <= '0;
      pc_r   <= '0;
      prev_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        done_r <= 1'b0;
      end
      if (cmd.walk_step) begin
        if (publish) begin
          pc_r   <= wc_r;
          done_r <= 1'b1;
        end
        bank_r <= bank_eff;
        wc_r   <= store_ok ? wc_eff + 1'b1 : wc_eff;
        prev_r <= angle_r;
      end
      if (cmd.finish_load && op_r == OP_TAKE) begin
        pc_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && store_ok) begin
      scan_mem[wr_addr] <= pkt_pts_r[walk_idx];
    end
    if (cmd.exec && op_r == OP_READ && idx_ok) begin
      rd_r <= scan_mem[rd_addr];
    end
  end

  // Result assembly.
  assign res_dist  = (op_r == OP_READ && idx_ok) ? rd_r[15:0]  : '0;
  assign res_conf  = (op_r == OP_READ && idx_ok) ? rd_r[23:16] : '0;
  assign cnt11     = 11'(pc_r);
  assign res_bytes = {cnt11[9:0], 1'b0} + cnt11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_load) begin
      out_tdata_r <= {3'b000, res_bytes, 9'(pc_r), res_conf, res_dist,
                      (op_r == OP_RX) && done_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_ALWAYS(a_wc_cap, 32'(wc_r) <= 32'(MAX_POINTS))
  `ASSERT_ALWAYS(a_pos_range, 32'(pos_r) < 32'(PACKET_LEN))
  `ASSERT_IMPL(a_span_reduced, cmd.div_init, span_r < SPAN_W'(FULL_TURN))
  `ASSERT_NEXT(a_publish_restart, cmd.walk_step && publish, wc_r == CW'(1))
  `ASSERT_NEXT(a_result_valid, cmd.finish_load, out_valid_r)

endmodule

// ===== rtl/lidar_packet_scan_assembler.sv =====
// A read, a count take or a non-final byte passes from acceptance through the execute and
// finish states into the output register; the final byte of a packet also passes through
// span reduction and a walk over all POINTS_PER_PACKET points before the finish state.
// One beat in flight: the next is taken once the result sits in the output register, which
// the finish state loads only when that register is free.
// Reset: synchronous, active low; clears framing, bank, counts and handshakes, not memory.
// ---------------------------------------------------------------------------
// Lidar packet scan assembler
// Frames lidar serial packets, interpolates point angles and assembles
// rotations into a double-banked scan memory that can be read back.
// ---------------------------------------------------------------------------
module lidar_packet_scan_assembler import lpsa_pkg::*; #(
  parameter int unsigned MAX_POINTS        = 450,
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte[7:0], read_index[16:8], zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // op[1:0]
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // scan_done[0], point_distance[16:1],
                                             // point_confidence[24:17],
                                             // published_points[33:25],
                                             // published_bytes[44:34], zero pad
);

  // Index width for the per-packet point buffer.
  localparam int unsigned PIDX_W = (POINTS_PER_PACKET > 1) ? $clog2(POINTS_PER_PACKET) : 1;

  lpsa_cmd_t         cmd;
  lpsa_status_t      status;
  logic [PIDX_W-1:0] walk_idx;

  // The controller owns the handshake on the input side and every sequencing
  // decision; it only sees the datapath through the status struct.
  lpsa_ctrl #(
    .POINTS_PER_PACKET (POINTS_PER_PACKET),
    .PIDX_W            (PIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .walk_idx  (walk_idx)
  );

  // The datapath holds framing state, the divider, the scan memory banks and
  // the output register, which lets a finished beat wait for the consumer
  // while the controller goes back to accepting input.
  lpsa_dpath #(
    .MAX_POINTS        (MAX_POINTS),
    .POINTS_PER_PACKET (POINTS_PER_PACKET),
    .PIDX_W            (PIDX_W)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .walk_idx      (walk_idx),
    .status        (status),
    .in_op         (in_tuser[1:0]),
    .in_rx_byte    (in_tdata[7:0]),
    .in_read_index (in_tdata[16:8]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata)
  );

endmodule

// ===== tb/sv/tb_lidar_packet_scan_assembler.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Lidar packet scan assembler testbench
// Feeds serial bytes, point reads and count takes over the input stream and
// checks every result beat against a cycle-free predictor of the framer,
// the angle interpolation and the double-banked scan store.
// ---------------------------------------------------------------------------
module tb_lidar_packet_scan_assembler;
  import lpsa_pkg::*;

  localparam int unsigned MAX_POINTS        = 450;
  localparam int unsigned POINTS_PER_PACKET = 12;
  localparam int unsigned END_ANGLE_POS     = POINTS_START + 3 * POINTS_PER_PACKET;
  localparam int unsigned PACKET_LEN        = END_ANGLE_POS + 5;

  // Op code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_BEATS    = 1000;
  localparam int MAX_GAP         = 17;
  // The receiver stops taking results for this long once, at beat HOLD_AT.
  localparam int HOLD_AT         = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  // A final packet byte is the slowest beat; leave room for stray beats.
  localparam int DRAIN_CYCLES    = 60;
  // Slowest run is about a thousand beats with their gaps and walks;
  // this limit is many times what they take.
  localparam int LIMIT_CYCLES    = 1200000;
  localparam int MAX_REPORTS     = 20;
  localparam int DIRECTED_ROWS   = 17;

  // One result beat, packed so that it lines up with out_tdata[44:0]:
  // scan_done at bit 0 up to the byte length at bits 44:34.
  typedef struct packed {
    logic [10:0] bytes_len;
    logic [8:0]  points;
    logic [7:0]  confidence;
    logic [15:0] distance;
    logic        scan_done;
  } scan_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [7:0]   rx_byte;
    logic [8:0]   read_index;
    logic         typed;
    scan_result_t want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  lidar_packet_scan_assembler #(
    .MAX_POINTS       (MAX_POINTS),
    .POINTS_PER_PACKET(POINTS_PER_PACKET)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted state of the block. It starts out as the block does after
  // reset, and reset is applied only once, before the first beat.
  int unsigned  frame_pos       = 0;
  logic [15:0]  pkt_start_angle = '0;
  logic [15:0]  pkt_end_angle   = '0;
  logic [23:0]  pkt_points [POINTS_PER_PACKET];
  logic [23:0]  bank_points [2][MAX_POINTS];
  bit           fill_bank       = 1'b0;
  int unsigned  fill_count      = 0;
  int unsigned  shown_count     = 0;
  int unsigned  last_angle      = 0;
  // Entries are written from index 0 upward, so the written part of each
  // bank is a prefix; reads stay inside it or beyond the array.
  int unsigned  bank_written [2] = '{0, 0};

  scan_result_t pending_results [$];

  int  errors           = 0;
  int  beats_sent       = 0;
  int  packets_sent     = 0;
  int  reads_sent       = 0;
  int  takes_sent       = 0;
  int  scans_published  = 0;
  int  points_dropped   = 0;
  bit  send_burst       = 1'b0;
  bit  recv_burst       = 1'b0;

  // Directed rows right after reset. Nothing has been published yet, so
  // every typed expectation is all zero; rows with typed clear go through
  // the predictor instead.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_TAKE,   8'h00, 9'd0,   1'b1, '0},  // take with nothing published
    '{OP_TAKE,   8'hff, 9'd511, 1'b1, '0},
    '{OP_UNUSED, 8'hff, 9'd511, 1'b1, '0},  // unused op changes nothing
    '{OP_UNUSED, 8'h54, 9'd0,   1'b1, '0},  // and does not start framing
    '{OP_READ,   8'h00, 9'd450, 1'b1, '0},  // first index past the store
    '{OP_READ,   8'hff, 9'd511, 1'b1, '0},  // largest index
    '{OP_RX,     8'h00, 9'd0,   1'b1, '0},  // not a header, dropped
    '{OP_RX,     8'hff, 9'd511, 1'b1, '0},
    '{OP_RX,     8'h2c, 9'd0,   1'b1, '0},  // second header byte out of place
    '{OP_RX,     8'h54, 9'd0,   1'b0, '0},  // header starts framing
    '{OP_RX,     8'h2d, 9'd0,   1'b1, '0},  // bad second byte restarts
    '{OP_RX,     8'h2c, 9'd0,   1'b1, '0},  // and the bad byte is not rechecked
    '{OP_RX,     8'h54, 9'd511, 1'b0, '0},
    '{OP_RX,     8'h54, 9'd0,   1'b1, '0},  // repeated header is a bad second byte
    '{OP_RX,     8'h2c, 9'd0,   1'b1, '0},  // framing is back at the start
    '{OP_READ,   8'h00, 9'd480, 1'b1, '0},
    '{OP_TAKE,   8'h00, 9'd0,   1'b0, '0}
  };

  // Walks the points of a completed packet from the start angle, publishing
  // the working bank every time the angle goes backward.
  function automatic bit interpolate_packet();
    int unsigned span;
    int unsigned step;
    int unsigned angle;
    bit          published;
    published = 1'b0;
    span  = (pkt_end_angle + 2 * FULL_TURN - pkt_start_angle) % FULL_TURN;
    step  = span / POINTS_PER_PACKET;
    angle = pkt_start_angle;
    for (int i = 0; i < POINTS_PER_PACKET; i++) begin
      if (angle < last_angle) begin
        shown_count = fill_count;
        fill_count  = 0;
        fill_bank   = ~fill_bank;
        published   = 1'b1;
      end
      if (fill_count < MAX_POINTS) begin
        bank_points[fill_bank][fill_count] = pkt_points[i];
        fill_count++;
        if (fill_count > bank_written[fill_bank]) bank_written[fill_bank] = fill_count;
      end else begin
        points_dropped++;
      end
      last_angle = angle & 32'hffff;
      angle += step;
      if (angle >= FULL_TURN) angle -= FULL_TURN;
    end
    return published;
  endfunction

  // Places one serial byte in the packet being framed.
  function automatic bit frame_byte(logic [7:0] c);
    int unsigned pos;
    int unsigned k;
    int unsigned part;
    pos = frame_pos;
    if (pos == 0) begin
      if (c == HEADER_BYTE) frame_pos = 1;
      return 1'b0;
    end
    if (pos == 1) begin
      frame_pos = (c == VERLEN_BYTE) ? 2 : 0;
      return 1'b0;
    end
    if (pos == 4) begin
      pkt_start_angle[7:0] = c;
    end else if (pos == 5) begin
      pkt_start_angle[15:8] = c;
    end else if (pos >= POINTS_START && pos < END_ANGLE_POS) begin
      k    = (pos - POINTS_START) / 3;
      part = (pos - POINTS_START) % 3;
      pkt_points[k][8*part +: 8] = c;
    end else if (pos == END_ANGLE_POS) begin
      pkt_end_angle[7:0] = c;
    end else if (pos == END_ANGLE_POS + 1) begin
      pkt_end_angle[15:8] = c;
    end
    if (pos + 1 >= PACKET_LEN) begin
      frame_pos = 0;
      return interpolate_packet();
    end
    frame_pos = pos + 1;
    return 1'b0;
  endfunction

  // Expected result of one accepted input beat; advances the predicted state.
  function automatic scan_result_t compute_scan_result(logic [1:0] op, logic [7:0] c,
                                                       logic [8:0] idx);
    scan_result_t r;
    logic [23:0]  p;
    r = '0;
    case (op)
      OP_RX: begin
        r.scan_done = frame_byte(c);
      end
      OP_READ: begin
        if (idx < MAX_POINTS) begin
          p = bank_points[~fill_bank][idx];
          r.distance   = p[15:0];
          r.confidence = p[23:16];
        end
      end
      default: begin
      end
    endcase
    r.points    = shown_count[8:0];
    r.bytes_len = 11'(3 * shown_count);
    if (op == OP_TAKE) shown_count = 0;
    return r;
  endfunction

  // Mostly written entries of the published bank, sometimes an index past
  // the store; never an entry that was never written.
  function automatic logic [8:0] pick_read_index();
    int unsigned written;
    written = bank_written[~fill_bank];
    if (written == 0 || $urandom_range(0, 7) == 0) return 9'($urandom_range(MAX_POINTS, 511));
    return 9'($urandom_range(0, written - 1));
  endfunction

  // Wait before the next beat; now and then a side switches to a stretch
  // without any idling.
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 49) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offers one beat, waits for it to be taken and queues what it must give.
  // Starts and ends at a falling edge.
  task automatic send_beat(logic [1:0] op, logic [7:0] c, logic [8:0] idx, logic typed,
                           scan_result_t want);
    int           gap;
    scan_result_t r;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({idx, c});
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    r = compute_scan_result(op, c, idx);
    pending_results.push_back(typed ? want : r);
    beats_sent++;
    if (op == OP_READ) reads_sent++;
    else if (op == OP_TAKE) takes_sent++;
    @(negedge clk);
  endtask

  task automatic send_side_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) send_beat(OP_READ, 8'($urandom), pick_read_index(), 1'b0, '0);
    else if (r < 17) send_beat(OP_TAKE, 8'($urandom), 9'($urandom), 1'b0, '0);
    else send_beat(OP_UNUSED, 8'($urandom), 9'($urandom), 1'b0, '0);
  endtask

  // Sends one packet with random speed, points, timestamp and checksum.
  // With bad_verlen set the second header byte is wrong, so the rest of the
  // packet arrives as loose bytes. Other ops are slipped in between bytes.
  task automatic send_packet(logic [15:0] from_angle, logic [15:0] to_angle, bit bad_verlen);
    logic [7:0] pkt [PACKET_LEN];
    logic [7:0] second;
    for (int i = 0; i < PACKET_LEN; i++) pkt[i] = 8'($urandom);
    second = 8'($urandom);
    if (second == VERLEN_BYTE) second ^= 8'h01;
    pkt[0]                 = HEADER_BYTE;
    pkt[1]                 = bad_verlen ? second : VERLEN_BYTE;
    pkt[4]                 = from_angle[7:0];
    pkt[5]                 = from_angle[15:8];
    pkt[END_ANGLE_POS]     = to_angle[7:0];
    pkt[END_ANGLE_POS + 1] = to_angle[15:8];
    for (int i = 0; i < PACKET_LEN; i++) begin
      if ($urandom_range(0, 15) == 0) send_side_op();
      send_beat(OP_RX, pkt[i], 9'($urandom), 1'b0, '0);
    end
    packets_sent++;
  endtask

  // Stimulus: reset, the directed rows, then rotations of well-formed packets
  // mixed with broken headers, loose bytes, reads and count takes.
  initial begin
    int          sweep;
    int          span;
    int          nxt;
    int          r;
    int          pkt_no;
    int          random_start;
    bit          slow_sweep;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].rx_byte, directed_rows[i].read_index,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // The first few packets are fixed corner cases; after that the sweep
    // advances packet by packet and wraps at a full turn. A slow sweep has
    // narrow packets, so one rotation holds more points than the cap.
    sweep        = $urandom_range(0, 2000);
    slow_sweep   = 1'b0;
    pkt_no       = 0;
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      case (pkt_no)
        0: send_packet(16'd1000, 16'd1000, 1'b0);    // zero span
        1: send_packet(16'd2000, 16'd1999, 1'b0);    // widest span
        2: send_packet(16'hffff, 16'h0000, 1'b0);    // angles beyond a full turn
        3: send_packet(16'd35990, 16'd700, 1'b0);    // wraps through zero
        4: send_packet(16'(sweep), 16'(sweep), 1'b0);
        default: begin
          span = slow_sweep ? $urandom_range(700, 800) : $urandom_range(1500, 9000);
          r    = $urandom_range(0, 39);
          if (!slow_sweep && r == 0) begin
            send_packet(16'($urandom), 16'($urandom), 1'b0);
          end else if (!slow_sweep && r == 1) begin
            send_packet(16'(sweep), 16'(sweep), 1'b0);
          end else if (r == 2) begin
            send_packet(16'(sweep), 16'((sweep + span) % FULL_TURN), 1'b1);
          end else if (r == 3) begin
            repeat ($urandom_range(1, 6)) send_beat(OP_RX, 8'($urandom), 9'($urandom), 1'b0, '0);
          end else begin
            nxt = sweep + span;
            send_packet(16'(sweep), 16'(nxt % FULL_TURN), 1'b0);
            if (nxt >= FULL_TURN) begin
              slow_sweep = (points_dropped == 0 && beats_sent - random_start >= RANDOM_BEATS / 2)
                           || $urandom_range(0, 5) == 0;
            end
            sweep = nxt % FULL_TURN;
          end
        end
      endcase
      repeat ($urandom_range(0, 3)) send_side_op();
      pkt_no++;
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d packets, %0d point reads, %0d count takes.",
             beats_sent, packets_sent, reads_sent, takes_sent);
    $display("Saw %0d beats that published a rotation; %0d points were dropped at the cap.",
             scans_published, points_dropped);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Result side: random back-pressure, one long hold-off, and a field by
  // field compare of each beat against the oldest expectation.
  initial begin
    int           gap;
    int           seen;
    scan_result_t got;
    scan_result_t want;
    seen       = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (seen == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[44:0];
      seen++;
      if (got.scan_done === 1'b1) scans_published++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                   $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("scan_done", 16'(want.scan_done), 16'(got.scan_done));
        check_field("point_distance", want.distance, got.distance);
        check_field("point_confidence", 16'(want.confidence), 16'(got.confidence));
        check_field("published_points", 16'(want.points), 16'(got.points));
        check_field("published_bytes", 16'(want.bytes_len), 16'(got.bytes_len));
      end
      @(negedge clk);
    end
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Run did not drain before the time limit.");
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== lidar_packet_scan_assembler.f =====
+incdir+rtl
rtl/lpsa_pkg.sv
rtl/lpsa_ctrl.sv
rtl/lpsa_dpath.sv
rtl/lidar_packet_scan_assembler.sv
tb/sv/tb_lidar_packet_scan_assembler.sv
